// ===== src/jsu_pkg.sv =====
// Shared types and status codes for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // String status codes carried on the result channel
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_CLOSED    = 3'd1;
  localparam logic [2:0] ST_NO_QUOTE  = 3'd2;
  localparam logic [2:0] ST_BAD_ESC   = 3'd3;
  localparam logic [2:0] ST_BAD_HEX   = 3'd4;
  localparam logic [2:0] ST_BAD_SURR  = 3'd5;
  localparam logic [2:0] ST_CTRL_CHAR = 3'd6;

  // One decoded input byte: up to four output words
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final word
    logic            has_data;
    logic [2:0]      status;
  } jsu_desc_t;

endpackage

// ===== src/jsu_front.sv =====
// Front end: escape decoder and UTF-8 encoder, one input word per cycle while take is high.
`timescale 1ns / 1ps

module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        in_byte,
  output jsu_pkg::jsu_desc_t desc
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_PLAIN, M_ESC, M_HEX1, M_NEED_BS, M_NEED_U, M_HEX2
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hi_r, hi_nxt;     // low ten bits of the pending high surrogate

  logic [4:0]  hex;              // {valid, nibble}
  logic [15:0] val;
  logic [20:0] cp;

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic jsu_desc_t one_byte(input logic [7:0] b);
    jsu_desc_t d;
    d = '0;
    d.bytes[0] = b;
    d.has_data = 1'b1;
    return d;
  endfunction

  function automatic jsu_desc_t status_only(input logic [2:0] st);
    jsu_desc_t d;
    d = '0;
    d.status = st;
    return d;
  endfunction

  function automatic jsu_desc_t utf8(input logic [20:0] u);
    jsu_desc_t d;
    d = '0;
    d.has_data = 1'b1;
    if (u <= 21'h7F) begin
      d.bytes[0] = u[7:0];
      d.last_idx = 2'd0;
    end else if (u <= 21'h7FF) begin
      d.bytes[0] = {3'b110, u[10:6]};
      d.bytes[1] = {2'b10, u[5:0]};
      d.last_idx = 2'd1;
    end else if (u <= 21'hFFFF) begin
      d.bytes[0] = {4'b1110, u[15:12]};
      d.bytes[1] = {2'b10, u[11:6]};
      d.bytes[2] = {2'b10, u[5:0]};
      d.last_idx = 2'd2;
    end else begin
      d.bytes[0] = {5'b11110, u[20:18]};
      d.bytes[1] = {2'b10, u[17:12]};
      d.bytes[2] = {2'b10, u[11:6]};
      d.bytes[3] = {2'b10, u[5:0]};
      d.last_idx = 2'd3;
    end
    return d;
  endfunction

  assign hex = hex_of(in_byte);
  assign val = {acc_r[11:0], hex[3:0]};
  // Surrogate pair to code point: ten bits each, plus the plane offset
  assign cp  = {1'b0, hi_r, val[9:0]} + 21'h10000;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    desc     = status_only(ST_BUSY);
    unique case (mode_r)
      M_PLAIN: begin
        if (in_byte == CH_QUOTE) begin
          desc = status_only(ST_CLOSED);
        end else if (in_byte == 8'h00) begin
          desc = status_only(ST_NO_QUOTE);
        end else if (in_byte == CH_BSL) begin
          mode_nxt = M_ESC;
        end else if (in_byte < CH_SPACE) begin
          desc = status_only(ST_CTRL_CHAR);
        end else begin
          desc = one_byte(in_byte);
        end
      end
      M_ESC: begin
        mode_nxt = M_PLAIN;
        unique case (in_byte)
          CH_QUOTE: desc = one_byte(CH_QUOTE);
          CH_BSL:   desc = one_byte(CH_BSL);
          CH_SLASH: desc = one_byte(CH_SLASH);
          CH_B:     desc = one_byte(8'h08);
          CH_F:     desc = one_byte(8'h0C);
          CH_N:     desc = one_byte(8'h0A);
          CH_R:     desc = one_byte(8'h0D);
          CH_T:     desc = one_byte(8'h09);
          CH_U: begin
            mode_nxt = M_HEX1;
            cnt_nxt  = 2'd0;
            acc_nxt  = 16'd0;
          end
          default:  desc = status_only(ST_BAD_ESC);
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (!hex[4]) begin
          desc = status_only(ST_BAD_HEX);
        end else if (cnt_r != 2'd3) begin
          acc_nxt = val;
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          cnt_nxt = 2'd0;
          acc_nxt = 16'd0;
          if (mode_r == M_HEX1) begin
            if (val >= 16'hD800 && val <= 16'hDBFF) begin
              hi_nxt   = val[9:0];
              mode_nxt = M_NEED_BS;
            end else begin
              mode_nxt = M_PLAIN;
              desc     = utf8({5'd0, val});
            end
          end else if (val < 16'hDC00 || val > 16'hDFFF) begin
            desc = status_only(ST_BAD_SURR);
          end else begin
            hi_nxt   = 10'd0;
            mode_nxt = M_PLAIN;
            desc     = utf8(cp);
          end
        end
      end
      M_NEED_BS: begin
        if (in_byte != CH_BSL) begin
          desc = status_only(ST_BAD_SURR);
        end else begin
          mode_nxt = M_NEED_U;
        end
      end
      M_NEED_U: begin
        if (in_byte != CH_U) begin
          desc = status_only(ST_BAD_SURR);
        end else begin
          mode_nxt = M_HEX2;
          cnt_nxt  = 2'd0;
          acc_nxt  = 16'd0;
        end
      end
      default: begin
        mode_nxt = M_PLAIN;
        cnt_nxt  = 2'd0;
        acc_nxt  = 16'd0;
        hi_nxt   = 10'd0;
      end
    endcase
    // closing quote or any error drops the whole decode state
    if (desc.status != ST_BUSY) begin
      mode_nxt = M_PLAIN;
      cnt_nxt  = 2'd0;
      acc_nxt  = 16'd0;
      hi_nxt   = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      cnt_r  <= 2'd0;
      acc_r  <= 16'd0;
      hi_r   <= 10'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hi_r   <= hi_nxt;
    end
  end

endmodule

// ===== src/jsu_queue.sv =====
// Short descriptor queue between the decoder and the output serialiser.
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsu_pkg::jsu_desc_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output jsu_pkg::jsu_desc_t head
);
  import jsu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_desc_t        slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/jsu_back.sv =====
// Back end: plays one descriptor out as one to four result words.
`timescale 1ns / 1ps

module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  jsu_pkg::jsu_desc_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_has_data,
  output logic [2:0]         out_status,
  output logic               out_last_of_run
);
  import jsu_pkg::*;

  jsu_desc_t  cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       taken;

  assign out_valid       = busy_r;
  assign out_byte        = cur_r.bytes[idx_r];
  assign out_has_data    = cur_r.has_data;
  assign out_status      = cur_r.status;
  assign out_last_of_run = (idx_r == cur_r.last_idx);

  assign taken = busy_r && !out_stall;
  // refill on the same edge the final word leaves
  assign q_pop = q_not_empty && (!busy_r || (taken && out_last_of_run));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (taken) begin
      if (out_last_of_run) begin
        busy_r <= 1'b0;
        idx_r  <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

endmodule

// ===== src/json_string_unescape_utf8_unit.sv =====
// Top level of the JSON string body unescaper with UTF-8 output.
`timescale 1ns / 1ps

// Takes the bytes of a JSON string body, one word per cycle, starting after
// the opening quote, and returns the unescaped text as UTF-8 bytes. Plain
// bytes pass through; the short escapes and \uXXXX (with surrogate pairs)
// are decoded, and each code point leaves as one to four result words.
// Every input word causes at least one result word; last_of_run marks its
// final one. A closing quote (status closed) or any error ends the string
// with a single status word and the block is ready for the next string.
// Rate: the decoder accepts one word per cycle whenever the descriptor
// queue (QUEUE_DEPTH entries) has room; the serialiser sends one result word
// per cycle while out_stall is low, so an input word that expands to k bytes
// holds the output for k result words, and the queue absorbs such bursts
// while escapes and hex digits (which produce only a busy word) let it
// drain. The first result of a word becomes valid once it has been written
// into the queue and then loaded into the serialiser's output register.
// in_stall is high exactly when the queue is full.

module json_string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = 4   // 2 or more
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_data,
  output logic [2:0] out_status,
  output logic       out_last_of_run
);
  import jsu_pkg::*;

  jsu_desc_t front_desc;
  jsu_desc_t q_head;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      in_take;

  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  // decoder: state advances only on an accepted word
  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_take),
    .in_byte (in_byte),
    .desc    (front_desc)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_desc),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // serialiser: holds the current descriptor as the output register
  jsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_has_data    (out_has_data),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== test/tb_json_string_unescape_utf8_unit.sv =====
// Testbench for the JSON string unescaper: predicted UTF-8 words checked against the block.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_unit;
  import jsu_pkg::*;

  // Decoder position within a string body
  typedef enum logic [2:0] {
    DM_PLAIN, DM_ESC, DM_HEX1, DM_NEED_BS, DM_NEED_U, DM_HEX2
  } dec_mode_t;

  // One result word as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic [2:0] status;
    logic       last;
  } out_word_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  // Shadow decoder plus the queue of words it has promised
  class utf8_scoreboard_t;
    dec_mode_t   mode;
    logic [1:0]  n_digits;
    logic [15:0] accum;
    logic [15:0] high_half;
    out_word_t   pending[$];
    int          errors;
    int          words_in;
    int          words_out;
    int          data_out;
    int          ends[8];

    function new();
      clear();
    endfunction

    function void clear();
      mode      = DM_PLAIN;
      n_digits  = 2'd0;
      accum     = 16'h0000;
      high_half = 16'h0000;
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    function void put_data(logic [7:0] b, logic last);
      out_word_t w;
      w = '{b, 1'b1, ST_BUSY, last};
      pending.insert(pending.size(), w);
    endfunction

    // single word with no data; any non-busy status ends the string
    function void put_status(logic [2:0] st);
      out_word_t w;
      w = '{8'h00, 1'b0, st, 1'b1};
      pending.insert(pending.size(), w);
      if (st != ST_BUSY) clear();
    endfunction

    function void put_code_point(logic [20:0] u);
      if (u <= 21'h7F) begin
        put_data(u[7:0], 1'b1);
      end else if (u <= 21'h7FF) begin
        put_data(8'hC0 | u[10:6], 1'b0);
        put_data(8'h80 | u[5:0], 1'b1);
      end else if (u <= 21'hFFFF) begin
        put_data(8'hE0 | u[15:12], 1'b0);
        put_data(8'h80 | u[11:6], 1'b0);
        put_data(8'h80 | u[5:0], 1'b1);
      end else begin
        put_data(8'hF0 | u[20:18], 1'b0);
        put_data(8'h80 | u[17:12], 1'b0);
        put_data(8'h80 | u[11:6], 1'b0);
        put_data(8'h80 | u[5:0], 1'b1);
      end
    endfunction

    // accepted input word: advance the shadow decoder, queue what it yields
    function void note_input(logic [7:0] c);
      int          h;
      logic [15:0] v;
      logic [20:0] cp;
      words_in++;
      case (mode)
        DM_PLAIN: begin
          if (c == CH_QUOTE) put_status(ST_CLOSED);
          else if (c == 8'h00) put_status(ST_NO_QUOTE);
          else if (c == CH_BSLASH) begin
            mode = DM_ESC;
            put_status(ST_BUSY);
          end else if (c < 8'h20) put_status(ST_CTRL_CHAR);
          else put_data(c, 1'b1);
        end
        DM_ESC: begin
          mode = DM_PLAIN;
          case (c)
            CH_QUOTE, CH_BSLASH, "/": put_data(c, 1'b1);
            "b": put_data(8'h08, 1'b1);
            "f": put_data(8'h0C, 1'b1);
            "n": put_data(8'h0A, 1'b1);
            "r": put_data(8'h0D, 1'b1);
            "t": put_data(8'h09, 1'b1);
            CH_U: begin
              mode     = DM_HEX1;
              n_digits = 2'd0;
              accum    = 16'h0000;
              put_status(ST_BUSY);
            end
            default: put_status(ST_BAD_ESC);
          endcase
        end
        DM_HEX1, DM_HEX2: begin
          h = hex_nibble(c);
          if (h < 0) begin
            put_status(ST_BAD_HEX);
          end else begin
            v = {accum[11:0], h[3:0]};
            if (n_digits != 2'd3) begin
              accum    = v;
              n_digits = n_digits + 2'd1;
              put_status(ST_BUSY);
            end else begin
              n_digits = 2'd0;
              accum    = 16'h0000;
              if (mode == DM_HEX1) begin
                if (v >= 16'hD800 && v <= 16'hDBFF) begin
                  high_half = v;
                  mode      = DM_NEED_BS;
                  put_status(ST_BUSY);
                end else begin
                  mode = DM_PLAIN;
                  put_code_point({5'd0, v});
                end
              end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                put_status(ST_BAD_SURR);
              end else begin
                cp        = {1'b0, high_half[9:0], v[9:0]} + 21'h10000;
                high_half = 16'h0000;
                mode      = DM_PLAIN;
                put_code_point(cp);
              end
            end
          end
        end
        DM_NEED_BS: begin
          if (c != CH_BSLASH) put_status(ST_BAD_SURR);
          else begin
            mode = DM_NEED_U;
            put_status(ST_BUSY);
          end
        end
        DM_NEED_U: begin
          if (c != CH_U) put_status(ST_BAD_SURR);
          else begin
            mode     = DM_HEX2;
            n_digits = 2'd0;
            accum    = 16'h0000;
            put_status(ST_BUSY);
          end
        end
        default: begin
          clear();
          put_status(ST_BUSY);
        end
      endcase
    endfunction

    // accepted output word: compare with the oldest promise
    function void check_word(logic [7:0] b, logic hd, logic [2:0] st, logic last);
      out_word_t want;
      words_out++;
      if (pending.size() == 0) begin
        $error("unexpected word: out_byte %h has_data %b status %0d last_of_run %b",
               b, hd, st, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (b !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, b);
        errors++;
      end
      if (hd !== want.has_data) begin
        $error("out_has_data: expected %b, got %b", want.has_data, hd);
        errors++;
      end
      if (st !== want.status) begin
        $error("out_status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last_of_run: expected %b, got %b", want.last, last);
        errors++;
      end
      if (want.has_data) data_out++;
      if (want.status != ST_BUSY) ends[want.status]++;
    endfunction
  endclass

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_data;
  logic [2:0] out_status;
  logic       out_last_of_run;

  // idling switches and the long receiver hold-off request
  bit tx_gaps  = 1'b1;
  bit rx_gaps  = 1'b1;
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  logic [7:0]       burst[$];   // bytes of the string being built
  utf8_scoreboard_t sb;

  json_string_unescape_utf8_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_has_data    (out_has_data),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both handshakes are observed here, at the edge, on pre-edge values,
  // so the prediction sees exactly the words the block took and gave.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_byte);
      if (in_valid && in_stall) stall_cycles++;
      if (out_valid && !out_stall)
        sb.check_word(out_byte, out_has_data, out_status, out_last_of_run);
    end
  end

  // Receiver: random stall bursts, free-running stretches, and on request
  // one long hold-off that lets the descriptor queue fill right up.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // append one byte to the string being built
  function automatic void add_byte(logic [7:0] b);
    burst.insert(burst.size(), b);
  endfunction

  // hex digit for a nibble, upper or lower case at random
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_hex4(logic [15:0] v);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[4*i +: 4]));
  endfunction

  // one word on the input channel; returns at the edge it is taken
  task automatic send_byte(logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_burst();
    foreach (burst[i]) send_byte(burst[i]);
  endtask

  // sender pause: valid low until every promised word has come back or the wait limit runs out
  task automatic wait_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (sb.pending.size() != 0 && n < 5000);
  endtask

  // Random strings: mostly well-formed bodies (plain bytes, short escapes,
  // \u escapes of every UTF-8 length, surrogate pairs) closed by a quote;
  // the rest end in each kind of error, or are raw noise left mid-string.
  task automatic send_random_strings(int n_items);
    int          sent;
    int          kind;
    logic [7:0]  b;
    logic [15:0] v;
    logic [63:0] short_esc;
    sent      = 0;
    short_esc = "\"\\/bfnrt";
    while (sent < n_items) begin
      burst.delete();
      repeat ($urandom_range(0, 8)) begin
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
          b = 8'($urandom_range(8'h20, 8'hFF));
          if (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(8'h80, 8'hFF));
          add_byte(b);
        end else if (kind < 55) begin
          add_byte(CH_BSLASH);
          add_byte(short_esc[8*$urandom_range(0, 7) +: 8]);
        end else if (kind < 80) begin
          case ($urandom_range(0, 3))
            0:       v = 16'($urandom_range(16'h0000, 16'h007F));
            1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
            2:       v = 16'($urandom_range(16'h0800, 16'hFFFF));
            default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));  // lone low half
          endcase
          if (v >= 16'hD800 && v <= 16'hDBFF) v = v ^ 16'h0400;
          add_byte(CH_BSLASH);
          add_byte(CH_U);
          add_hex4(v);
        end else begin
          add_byte(CH_BSLASH);
          add_byte(CH_U);
          add_hex4(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
          add_byte(CH_BSLASH);
          add_byte(CH_U);
          add_hex4(16'hDC00 + 16'($urandom_range(0, 16'h3FF)));
        end
      end
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        add_byte(CH_QUOTE);
      end else if (kind < 70) begin
        add_byte(8'h00);
      end else if (kind < 75) begin
        add_byte(8'($urandom_range(1, 31)));
      end else if (kind < 80) begin
        // unknown escape letter, sometimes the zero byte
        add_byte(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) b = 8'h00;
        else do b = 8'($urandom); while (b inside {CH_QUOTE, CH_BSLASH, "/", "b", "f",
                                                     "n", "r", "t", CH_U});
        add_byte(b);
      end else if (kind < 85) begin
        // \u cut short by a non-hex byte
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
        if ($urandom_range(0, 3) == 0) b = 8'h00;
        else do b = 8'($urandom); while (sb.hex_nibble(b) >= 0);
        add_byte(b);
      end else if (kind < 95) begin
        // high half with a broken follow-up
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        add_hex4(16'hD800 + 16'($urandom_range(0, 16'h3FF)));
        case ($urandom_range(0, 3))
          0: begin
            do b = 8'($urandom); while (b == CH_BSLASH);
            add_byte(b);
          end
          1: begin
            add_byte(CH_BSLASH);
            do b = 8'($urandom); while (b == CH_U);
            add_byte(b);
          end
          2: begin
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
            add_hex4(v);
          end
          default: begin
            if ($urandom_range(0, 1)) add_byte(CH_BSLASH);
            add_byte(8'h00);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      end
      send_burst();
      sent += burst.size();
    end
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain extremes, the largest pair (upper- and lower-case digits),
    // unknown escape, control byte, zero after a backslash, zero in plain
    // text, \u0000 and a closing quote.
    burst = '{8'h20, 8'h7F, 8'h80, 8'hFF,
              CH_BSLASH, CH_U, "D", "B", "F", "F", CH_BSLASH, CH_U, "d", "f", "f", "f",
              CH_BSLASH, "q", 8'h1F, CH_BSLASH, 8'h00, 8'h00,
              CH_BSLASH, CH_U, "0", "0", "0", "0", CH_QUOTE};
    send_burst();
    wait_drained();

    send_random_strings(130);

    // long receiver hold-off with the sender flat out
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    send_random_strings(40);
    while (hold_req) @(posedge clk);
    wait_drained();
    tx_gaps = 1'b1;

    send_random_strings(90);

    // closing stretch with no idling on either side
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random_strings(50);
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $error("%0d expected words never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d input words, %0d result words, %0d data bytes, %0d stalled cycles",
             sb.words_in, sb.words_out, sb.data_out, stall_cycles);
    $display("Strings closed %0d; errors: quote %0d, escape %0d, hex %0d, surr %0d, ctrl %0d",
             sb.ends[ST_CLOSED], sb.ends[ST_NO_QUOTE], sb.ends[ST_BAD_ESC],
             sb.ends[ST_BAD_HEX], sb.ends[ST_BAD_SURR], sb.ends[ST_CTRL_CHAR]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
